[hdl/ddd_pkg.sv]
// Shared types, constants and calendar functions for the date day-distance core.
// Used by ddd_ctrl, ddd_datapath and date_day_distance_core.
`timescale 1ns / 1ps
`default_nettype none

package ddd_pkg;

   // Field widths
   localparam int DayW   = 5;
   localparam int MonthW = 4;
   localparam int YearW  = 14;
   localparam int DistW  = 22;
   localparam int AccW   = 23;            // accumulator, holds 16383 years of 366 days
   localparam int ResW   = 9;             // year mod 400
   localparam int DoyW   = 9;             // day of year, 0..366
   localparam int CntW   = YearW + 1;     // running year, can pass the top year by one
   localparam int QuotW  = 6;             // year / 400 for a 14-bit year
   localparam int ProdW  = 2 * YearW;

   // year / 400 == (year * RecipMul) >> RecipShift, exact for year < 43690
   localparam logic [YearW-1:0] RecipMul   = 14'd10486;
   localparam int               RecipShift = 22;

   localparam logic [ResW-1:0] CycleLen  = 9'd400;
   localparam logic [ResW-1:0] CycleLast = 9'd399;
   localparam logic [ResW-1:0] Century1  = 9'd100;
   localparam logic [ResW-1:0] Century2  = 9'd200;
   localparam logic [ResW-1:0] Century3  = 9'd300;

   localparam logic [DoyW-1:0] CommonYearLen = 9'd365;
   localparam logic [AccW-1:0] DistMax       = 23'h3FFFFF;

   // Month codes that the logic tests by name
   localparam logic [MonthW-1:0] MonthNone = 4'd0;
   localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
   localparam logic [MonthW-1:0] MonthDec  = 4'd12;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MUL  = 6'b000010,
      ST_RES  = 6'b000100,
      ST_DOY  = 6'b001000,
      ST_LOOP = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture and order the request
      logic mul;        // reciprocal multiply for year / 400
      logic res;        // form year mod 400
      logic doy;        // day of year and first partial distance
      logic step;       // add one whole year
      logic out_load;   // move the distance to the result register
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic loop_done;  // no whole years left to add
   } status_type;

   // Leap test on year mod 400
   function automatic logic is_leap(input logic [ResW-1:0] r);
      logic cent;
      cent = (r == Century1) || (r == Century2) || (r == Century3);
      return (r[1:0] == 2'b00) && !cent;
   endfunction

   // Days in month; zero for a code that is no month
   function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
      logic [DayW-1:0] v;
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   v = 5'd30;
         MonthFeb:                                   v = leap ? 5'd29 : 5'd28;
         default:                                    v = 5'd0;
      endcase
      return v;
   endfunction

   // Days before the first of the month in a common year
   function automatic logic [DoyW-1:0] month_start(input logic [MonthW-1:0] m);
      logic [DoyW-1:0] v;
      case (m)
         4'd1:    v = 9'd0;
         4'd2:    v = 9'd31;
         4'd3:    v = 9'd59;
         4'd4:    v = 9'd90;
         4'd5:    v = 9'd120;
         4'd6:    v = 9'd151;
         4'd7:    v = 9'd181;
         4'd8:    v = 9'd212;
         4'd9:    v = 9'd243;
         4'd10:   v = 9'd273;
         4'd11:   v = 9'd304;
         4'd12:   v = 9'd334;
         default: v = 9'd0;
      endcase
      return v;
   endfunction

   // Day of the year; zero for a bad month or a day past the month end
   function automatic logic [DoyW-1:0] day_of_year(input logic [DayW-1:0]   d,
                                                   input logic [MonthW-1:0] m,
                                                   input logic              leap);
      logic [DoyW-1:0] v;
      if ((m == MonthNone) || (m > MonthDec)) begin
         v = '0;
      end else if (d > month_len(m, leap)) begin
         v = '0;
      end else begin
         v = month_start(m) + DoyW'(leap && (m > MonthFeb)) + DoyW'(d);
      end
      return v;
   endfunction

endpackage

`default_nettype wire

[hdl/ddd_ctrl.sv]
// Sequencer for the date day-distance core: one-hot state machine and result valid.
// Depends on ddd_pkg; drives ddd_datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps
`default_nettype none

module ddd_ctrl
   import ddd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output cmd_type         cmd,
   input  wire status_type status
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Result register can take a new value
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_RES;
         end
         ST_RES: begin
            cmd.res  = 1'b1;
            state_in = ST_DOY;
         end
         ST_DOY: begin
            cmd.doy  = 1'b1;
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            if (status.loop_done) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid: set on load, cleared when taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hdl/ddd_datapath.sv]
// Datapath for the date day-distance core: date ordering, year mod 400,
// day of year, year-by-year accumulation and the result register. Depends on ddd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ddd_datapath
   import ddd_pkg::*;
(
   input  wire logic              clock,
   input  wire cmd_type           cmd,
   output status_type             status,
   input  wire logic [DayW-1:0]   req_first_day,
   input  wire logic [MonthW-1:0] req_first_month,
   input  wire logic [YearW-1:0]  req_first_year,
   input  wire logic [DayW-1:0]   req_second_day,
   input  wire logic [MonthW-1:0] req_second_month,
   input  wire logic [YearW-1:0]  req_second_year,
   output logic [DistW-1:0]       rsp_day_distance
);

   // Ordered dates
   logic [DayW-1:0]   d1_ff, d2_ff;
   logic [MonthW-1:0] m1_ff, m2_ff;
   logic [YearW-1:0]  y1_ff, y2_ff;
   // year / 400 and year mod 400
   logic [QuotW-1:0]  q1_ff, q2_ff;
   logic [ResW-1:0]   r1_ff, r2_ff;
   // Year walk
   logic [CntW-1:0]   year_ff;
   logic [ResW-1:0]   res_ff;
   logic [AccW-1:0]   dist_ff;
   logic [DistW-1:0]  out_ff;

   logic              swap;
   logic [ProdW-1:0]  prod1, prod2;
   logic [YearW-1:0]  rem1, rem2;
   logic              leap1, leap2;
   logic [DoyW-1:0]   o1, o2;
   logic [AccW-1:0]   dist_init;
   logic [ResW-1:0]   res_next;
   logic [ResW-1:0]   res_start;

   // First date later than second: swap (lexicographic year, month, day)
   assign swap = {req_first_year, req_first_month, req_first_day} >
                 {req_second_year, req_second_month, req_second_day};

   // Reciprocal multiply for the quotient by 400
   assign prod1 = y1_ff * RecipMul;
   assign prod2 = y2_ff * RecipMul;

   // Remainder after removing whole 400-year cycles
   assign rem1 = y1_ff - YearW'(q1_ff) * YearW'(CycleLen);
   assign rem2 = y2_ff - YearW'(q2_ff) * YearW'(CycleLen);

   assign leap1 = is_leap(r1_ff);
   assign leap2 = is_leap(r2_ff);
   assign o1    = day_of_year(d1_ff, m1_ff, leap1);
   assign o2    = day_of_year(d2_ff, m2_ff, leap2);

   // Partial distance: same year, or rest of first year plus start of last
   always_comb begin
      if (y1_ff == y2_ff) begin
         dist_init = (o2 >= o1) ? AccW'(o2 - o1) : AccW'(o1 - o2);
      end else begin
         dist_init = AccW'(CommonYearLen) + AccW'(leap1) - AccW'(o1) + AccW'(o2);
      end
   end

   assign res_start = (r1_ff == CycleLast) ? '0 : r1_ff + 1'b1;
   assign res_next  = (res_ff == CycleLast) ? '0 : res_ff + 1'b1;

   assign status.loop_done = (year_ff >= CntW'(y2_ff));

   // Request capture in order
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (swap) begin
            d1_ff <= req_second_day;
            m1_ff <= req_second_month;
            y1_ff <= req_second_year;
            d2_ff <= req_first_day;
            m2_ff <= req_first_month;
            y2_ff <= req_first_year;
         end else begin
            d1_ff <= req_first_day;
            m1_ff <= req_first_month;
            y1_ff <= req_first_year;
            d2_ff <= req_second_day;
            m2_ff <= req_second_month;
            y2_ff <= req_second_year;
         end
      end
   end

   // Quotient and remainder registers
   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         q1_ff <= prod1[RecipShift +: QuotW];
         q2_ff <= prod2[RecipShift +: QuotW];
      end
      if (cmd.res) begin
         r1_ff <= rem1[ResW-1:0];
         r2_ff <= rem2[ResW-1:0];
      end
   end

   // Accumulation over the whole years in between
   always_ff @(posedge clock) begin
      if (cmd.doy) begin
         dist_ff <= dist_init;
         year_ff <= CntW'(y1_ff) + 1'b1;
         res_ff  <= res_start;
      end else if (cmd.step) begin
         dist_ff <= dist_ff + AccW'(CommonYearLen) + AccW'(is_leap(res_ff));
         year_ff <= year_ff + 1'b1;
         res_ff  <= res_next;
      end
   end

   // Result register with saturation
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff <= (dist_ff > DistMax) ? DistMax[DistW-1:0] : dist_ff[DistW-1:0];
      end
   end

   assign rsp_day_distance = out_ff;

endmodule

`default_nettype wire

[hdl/date_day_distance_core.sv]
// Absolute day distance between two Gregorian dates.
// A request is ordered and split into year / 400 and year mod 400, then gives the days of
// year and a partial distance; the loop adds the whole years in between, one per step, and
// a new request is taken only back in idle. A result still waiting holds the next one in
// the sequencer, so the input stalls once that next request has been taken.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module date_day_distance_core
   import ddd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [DayW-1:0]   req_first_day,
   input  wire logic [MonthW-1:0] req_first_month,
   input  wire logic [YearW-1:0]  req_first_year,
   input  wire logic [DayW-1:0]   req_second_day,
   input  wire logic [MonthW-1:0] req_second_month,
   input  wire logic [YearW-1:0]  req_second_year,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [DistW-1:0]       rsp_day_distance
);

   cmd_type    cmd;
   status_type status;

   // Sequencer
   ddd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic and storage
   ddd_datapath u_datapath (
      .clock            (clock),
      .cmd              (cmd),
      .status           (status),
      .req_first_day    (req_first_day),
      .req_first_month  (req_first_month),
      .req_first_year   (req_first_year),
      .req_second_day   (req_second_day),
      .req_second_month (req_second_month),
      .req_second_year  (req_second_year),
      .rsp_day_distance (rsp_day_distance)
   );

endmodule

`default_nettype wire

[verif/tb_date_day_distance_core.sv]
// Self-checking testbench for date_day_distance_core: directed and random date pairs,
// with randomized request gaps and result stalls. Depends on ddd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_date_day_distance_core;
   import ddd_pkg::*;

   localparam int CycleLimit = 1_500_000;
   localparam int HoldCycles = 400;
   localparam int unsigned DistCeiling = (1 << DistW) - 1;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DayW-1:0]   req_first_day = '0;
   logic [MonthW-1:0] req_first_month = '0;
   logic [YearW-1:0]  req_first_year = '0;
   logic [DayW-1:0]   req_second_day = '0;
   logic [MonthW-1:0] req_second_month = '0;
   logic [YearW-1:0]  req_second_year = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [DistW-1:0]  rsp_day_distance;

   // expected day distances, oldest first
   logic [DistW-1:0] pending_dist[$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   int unsigned      max_gap = 7;
   int unsigned      max_stall = 7;
   int unsigned      stall_left = 0;
   logic             rsp_hold = 1'b0;
   event             hold_start;

   date_day_distance_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_first_day    (req_first_day),
      .req_first_month  (req_first_month),
      .req_first_year   (req_first_year),
      .req_second_day   (req_second_day),
      .req_second_month (req_second_month),
      .req_second_year  (req_second_year),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_day_distance (rsp_day_distance)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- calendar predictor

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned year_days(input int unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   // only called for months 1..12
   function automatic int unsigned days_in_month(input logic [MonthW-1:0] m,
                                                 input int unsigned y);
      int unsigned n;
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11: n = 30;
         MonthFeb:                n = leap_year(y) ? 29 : 28;
         default:                 n = 31;
      endcase
      return n;
   endfunction

   // day of year; zero for a month out of range or a day past the month end
   function automatic int unsigned ordinal_day(input logic [DayW-1:0] d,
                                               input logic [MonthW-1:0] m,
                                               input logic [YearW-1:0] y);
      int unsigned acc;
      acc = 0;
      if (m == MonthNone || m > MonthDec) return 0;
      if (d > days_in_month(m, y)) return 0;
      for (int i = 1; i < m; i++)
         acc += days_in_month(MonthW'(i), y);
      return acc + d;
   endfunction

   function automatic logic [DistW-1:0] days_between(
         input logic [DayW-1:0] d1, input logic [MonthW-1:0] m1, input logic [YearW-1:0] y1,
         input logic [DayW-1:0] d2, input logic [MonthW-1:0] m2, input logic [YearW-1:0] y2);
      logic [DayW-1:0]   ed, ld;
      logic [MonthW-1:0] em, lm;
      logic [YearW-1:0]  ey, ly;
      int unsigned       o1, o2, total;
      bit                swap;
      // put the earlier date first
      if (y1 != y2)      swap = y1 > y2;
      else if (m1 != m2) swap = m1 > m2;
      else               swap = d1 > d2;
      {ed, em, ey} = swap ? {d2, m2, y2} : {d1, m1, y1};
      {ld, lm, ly} = swap ? {d1, m1, y1} : {d2, m2, y2};
      o1 = ordinal_day(ed, em, ey);
      o2 = ordinal_day(ld, lm, ly);
      if (ey == ly) begin
         total = (o2 >= o1) ? o2 - o1 : o1 - o2;
      end else begin
         total = year_days(ey) - o1;
         for (int unsigned y = ey + 1; y < ly; y++)
            total += year_days(y);
         total += o2;
      end
      if (total > DistCeiling) total = DistCeiling;
      return DistW'(total);
   endfunction

   // ---------------------------------------------------------------- request driver

   task automatic send_dates(
         input logic [DayW-1:0] d1, input logic [MonthW-1:0] m1, input logic [YearW-1:0] y1,
         input logic [DayW-1:0] d2, input logic [MonthW-1:0] m2, input logic [YearW-1:0] y2);
      int unsigned gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_day    <= d1;
      req_first_month  <= m1;
      req_first_year   <= y1;
      req_second_day   <= d2;
      req_second_month <= m2;
      req_second_year  <= y2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_dist.push_back(days_between(d1, m1, y1, d2, m2, y2));
   endtask

   // ---------------------------------------------------------------- result side

   // long receiver hold-off, counted here
   initial forever begin
      @(hold_start);
      rsp_hold <= 1'b1;
      repeat (HoldCycles) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ready with a random stall after each result
   always @(posedge clock) begin
      if (reset || rsp_hold) begin
         rsp_ready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         stall_left = $urandom_range(0, max_stall);
         if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // compare each result with the oldest expected distance
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_dist.size() == 0) begin
            if (mismatch_count < 10)
               $display("%0t: unexpected result, day distance %0d", $time, rsp_day_distance);
            mismatch_count++;
         end else if (pending_dist[0] !== rsp_day_distance) begin
            if (mismatch_count < 10)
               $display("%0t: day distance mismatch, expected %0d, got %0d",
                        $time, pending_dist[0], rsp_day_distance);
            mismatch_count++;
            void'(pending_dist.pop_front());
         end else begin
            void'(pending_dist.pop_front());
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_same_year();
      send_dates(5'd1, 4'd1, 14'd2000, 5'd1, 4'd1, 14'd2000);
      send_dates(5'd31, 4'd12, 14'd2023, 5'd1, 4'd1, 14'd2023);
      send_dates(5'd29, 4'd2, 14'd2024, 5'd1, 4'd3, 14'd2024);
      send_dates(5'd15, 4'd6, 14'd2021, 5'd14, 4'd6, 14'd2021);
      send_dates(5'd28, 4'd2, 14'd2023, 5'd1, 4'd3, 14'd2023);
   endtask

   task automatic test_across_years();
      send_dates(5'd31, 4'd12, 14'd1999, 5'd1, 4'd1, 14'd2000);
      send_dates(5'd1, 4'd1, 14'd2001, 5'd1, 4'd1, 14'd1901);
      send_dates(5'd1, 4'd3, 14'd1900, 5'd1, 4'd3, 14'd2000);
      send_dates(5'd15, 4'd8, 14'd2023, 5'd15, 4'd8, 14'd2020);
   endtask

   task automatic test_special_cases();
      // day past the end of its month
      send_dates(5'd31, 4'd4, 14'd2023, 5'd1, 4'd5, 14'd2023);
      // Feb 29 in a century year that is not leap
      send_dates(5'd29, 4'd2, 14'd1900, 5'd1, 4'd1, 14'd1901);
      // day zero
      send_dates(5'd0, 4'd3, 14'd2023, 5'd0, 4'd1, 14'd2024);
      // month out of range
      send_dates(5'd10, 4'd0, 14'd2023, 5'd10, 4'd6, 14'd2023);
      send_dates(5'd1, 4'd13, 14'd2023, 5'd1, 4'd15, 14'd2025);
      // year zero counts as leap
      send_dates(5'd29, 4'd2, 14'd0, 5'd1, 4'd1, 14'd1);
      // same year, later date invalid
      send_dates(5'd1, 4'd3, 14'd2023, 5'd31, 4'd4, 14'd2023);
      send_dates(5'd31, 4'd15, 14'd16383, 5'd31, 4'd1, 14'd16382);
      send_dates(5'd29, 4'd2, 14'd2400, 5'd29, 4'd2, 14'd2399);
   endtask

   task automatic test_extremes();
      send_dates(5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999);
      // span past the 22-bit ceiling saturates
      send_dates(5'd1, 4'd1, 14'd0, 5'd31, 4'd12, 14'd16383);
      send_dates(5'd31, 4'd15, 14'd16383, 5'd0, 4'd0, 14'd0);
      send_dates(5'd31, 4'd12, 14'd9999, 5'd31, 4'd12, 14'd9999);
   endtask

   // receiver holds off while the sender keeps going, so the input stalls
   task automatic test_backpressure();
      max_gap = 0;
      -> hold_start;
      for (int i = 0; i < 12; i++)
         send_dates(5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)), 14'(2000 + i),
                    5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)), 14'(2001 + i));
      max_gap = 7;
   endtask

   task automatic test_random(input int count);
      logic [DayW-1:0]   d1, d2;
      logic [MonthW-1:0] m1, m2;
      int unsigned       y1, y2, span;
      for (int i = 0; i < count; i++) begin
         // alternate stretches with and without idling
         if (i % 60 == 0) begin
            max_gap   = ((i / 60) % 2 == 1) ? 0 : 7;
            max_stall = ((i / 60) % 3 == 1) ? 0 : 7;
         end
         if (i % 100 == 50) begin
            // a few long spans
            y1 = $urandom_range(0, 400);
            y2 = $urandom_range(9000, 16383);
         end else begin
            y1   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                               : $urandom_range(1, 9999);
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 2);
            y2   = (y1 + span > 16383) ? y1 - span : y1 + span;
         end
         if ($urandom_range(0, 3) != 0 && y1 >= 1 && y1 <= 9999 && y2 >= 1 && y2 <= 9999) begin
            // well-formed dates
            m1 = MonthW'($urandom_range(1, 12));
            m2 = MonthW'($urandom_range(1, 12));
            d1 = DayW'($urandom_range(1, days_in_month(m1, y1)));
            d2 = DayW'($urandom_range(1, days_in_month(m2, y2)));
         end else begin
            d1 = DayW'($urandom_range(0, 31));
            d2 = DayW'($urandom_range(0, 31));
            m1 = MonthW'($urandom_range(0, 15));
            m2 = MonthW'($urandom_range(0, 15));
         end
         if ($urandom_range(0, 1) == 1)
            send_dates(d2, m2, YearW'(y2), d1, m1, YearW'(y1));
         else
            send_dates(d1, m1, YearW'(y1), d2, m2, YearW'(y2));
      end
      max_gap   = 7;
      max_stall = 7;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_same_year();
      test_across_years();
      test_special_cases();
      test_extremes();
      test_backpressure();
      test_random(480);
      req_valid <= 1'b0;
      while (pending_dist.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
